// ===== rtl/rk4dm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4dm_pkg
// Shared constants, types and helper functions of the RK4 density matrix core.
// ----------------------------------------------------------------------------
package rk4dm_pkg;

    localparam int DIM        = 3;
    localparam int WORD_BITS  = 32;
    localparam int ENT        = DIM * DIM;
    localparam int ENT_W      = $clog2(ENT);
    localparam int IDX_W      = 2;
    localparam int H_FRAC     = WORD_BITS - 8;
    localparam int OPND_W     = WORD_BITS + 1;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int ACC_W      = 48;
    localparam int SUB_STEPS  = 2 * DIM;
    localparam int SUB_W      = $clog2(SUB_STEPS);
    localparam int STAGE_W    = 2;
    localparam int LAST_STAGE = 3;
    localparam int HALF_STAGE = 2;

    localparam int DIV_W      = 40;
    localparam int DIV_DIGIT  = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DIV_REM_W  = 3;
    localparam int DIVISOR    = 6;

    localparam logic [DIV_W-1:0]       DIV_OFFSET = DIV_W'(64'd6 << 35);
    localparam logic signed [ACC_W-1:0] Q_OFFSET  = ACC_W'(64'd1 << 35);

    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * IDX_W - 2 * WORD_BITS;

    localparam logic [1:0] OP_LOAD_H   = 2'd0;
    localparam logic [1:0] OP_LOAD_RHO = 2'd1;
    localparam logic [1:0] OP_STEP     = 2'd2;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2**(WORD_BITS-1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef struct packed {
        logic signed [PROD_W-1:0] rr;
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] ri;
        logic signed [PROD_W-1:0] ir;
    } prod_t;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             last;
        logic [ENT_W-1:0] ent;
    } tag_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_COMM = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIVW = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [ACC_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[WORD_BITS-1:0];
        end
        else if (v < SAT_LO) begin
            return SAT_LO[WORD_BITS-1:0];
        end
        return v[WORD_BITS-1:0];
    endfunction

    function automatic logic [ENT_W-1:0] ent_idx(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
        return ENT_W'(int'(r) * DIM + int'(c));
    endfunction

endpackage

// ===== rtl/rk4dm_cmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4dm_cmul
// Shared complex multiplier: the four real partial products, registered.
// ----------------------------------------------------------------------------
module rk4dm_cmul (
    input  logic                                clk,
    input  logic signed [rk4dm_pkg::OPND_W-1:0] a_re,
    input  logic signed [rk4dm_pkg::OPND_W-1:0] a_im,
    input  logic signed [rk4dm_pkg::OPND_W-1:0] b_re,
    input  logic signed [rk4dm_pkg::OPND_W-1:0] b_im,
    output rk4dm_pkg::prod_t                    prod
);

    rk4dm_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg.rr <= a_re * b_re;
        prod_reg.ii <= a_im * b_im;
        prod_reg.ri <= a_re * b_im;
        prod_reg.ir <= a_im * b_re;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/rk4dm_div6.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4dm_div6
// Unsigned division by six, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module rk4dm_div6 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rk4dm_pkg::DIV_W-1:0]     dividend,
    output logic [rk4dm_pkg::DIV_W-1:0]     quotient,
    output logic                            done
);

    logic [rk4dm_pkg::DIV_W-1:0]     quo_reg;
    logic [rk4dm_pkg::DIV_W-1:0]     quo_next;
    logic [rk4dm_pkg::DIV_REM_W-1:0] rem_reg;
    logic [rk4dm_pkg::DIV_REM_W-1:0] rem_next;
    logic [rk4dm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    always_comb
    begin
        logic [rk4dm_pkg::DIV_REM_W:0] rr;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < rk4dm_pkg::DIV_DIGIT; i++)
        begin
            rr       = {rem_next, quo_next[rk4dm_pkg::DIV_W-1]};
            quo_next = {quo_next[rk4dm_pkg::DIV_W-2:0],
                        rr >= (rk4dm_pkg::DIV_REM_W+1)'(rk4dm_pkg::DIVISOR)};
            if (rr >= (rk4dm_pkg::DIV_REM_W+1)'(rk4dm_pkg::DIVISOR))
            begin
                rr = rr - (rk4dm_pkg::DIV_REM_W+1)'(rk4dm_pkg::DIVISOR);
            end
            rem_next = rr[rk4dm_pkg::DIV_REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == rk4dm_pkg::DIV_CNT_W'(rk4dm_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/rk4_density_matrix_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4_density_matrix_step_core
// One RK4 step of d(rho)/dt = -i[H, rho] on a 3x3 complex density matrix.
// ----------------------------------------------------------------------------
// Load items are taken while idle. A step item runs four commutator stages
// of 54 complex products on one shared complex multiplier, three stage-point
// passes, and a final pass per entry through the radix-16 divide by six.
// Nine result transfers follow, one per cycle while m_tready is high.
// Reset sets rho to the identity's (0,0) entry only and H to zero.
module rk4_density_matrix_step_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // row_index, col_index, value_real, value_imag, time_step, zero pad
    input  logic [rk4dm_pkg::IN_TDATA_W-1:0]        s_tdata,
    // opcode
    input  logic [rk4dm_pkg::IN_TUSER_W-1:0]        s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // out_row, out_col, out_real, out_imag, zero pad
    output logic [rk4dm_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                    m_tlast
);

    localparam int W  = rk4dm_pkg::WORD_BITS;
    localparam int AW = rk4dm_pkg::ACC_W;
    localparam int NE = rk4dm_pkg::ENT;

    rk4dm_pkg::state_t state_reg, state_next;

    logic signed [W-1:0]  rho_re_reg [NE];
    logic signed [W-1:0]  rho_im_reg [NE];
    logic signed [W-1:0]  h_re_reg   [NE];
    logic signed [W-1:0]  h_im_reg   [NE];
    logic signed [W-1:0]  x_re_reg   [NE];
    logic signed [W-1:0]  x_im_reg   [NE];
    logic signed [W-1:0]  k_re_reg   [NE];
    logic signed [W-1:0]  k_im_reg   [NE];
    logic signed [AW-1:0] t_re_reg   [NE];
    logic signed [AW-1:0] t_im_reg   [NE];

    logic [rk4dm_pkg::STAGE_W-1:0] stage_reg;
    logic [rk4dm_pkg::IDX_W-1:0]   ri_reg, ci_reg, orow_reg, ocol_reg;
    logic [rk4dm_pkg::SUB_W-1:0]   sub_reg;
    logic                          iss_done_reg;
    logic [rk4dm_pkg::ENT_W-1:0]   ue_reg;
    logic                          uph_reg;
    logic [W-1:0]                  dt_reg;
    rk4dm_pkg::tag_t               tag1_reg, tag2_reg, tag_issue;
    logic signed [AW-1:0]          term_r_reg, term_i_reg;
    logic signed [AW-1:0]          acc_r_reg, acc_i_reg, acc_r_next, acc_i_next;

    logic                          in_xfer;
    logic [1:0]                    in_op;
    logic [rk4dm_pkg::IDX_W-1:0]   in_row, in_col;
    logic signed [W-1:0]           in_re, in_im;
    logic [W-1:0]                  in_dt;

    logic signed [rk4dm_pkg::OPND_W-1:0] a_re, a_im, b_re, b_im;
    rk4dm_pkg::prod_t              prod;

    logic [rk4dm_pkg::IDX_W-1:0]   a_sel;
    logic [rk4dm_pkg::ENT_W-1:0]   h_addr, x_addr, out_ent;
    logic signed [W-1:0]           hs_re, hs_im, xs_re, xs_im;

    logic signed [AW-1:0]          f_re, f_im, hh_re, hh_im, t_new_re, t_new_im;
    logic signed [W-1:0]           x_new_re, x_new_im;
    logic signed [AW-1:0]          tf_re, tf_im;
    logic                          div_start, div_done_re, div_done_im;
    logic [rk4dm_pkg::DIV_W-1:0]   quo_re, quo_im;
    logic signed [W-1:0]           rho_new_re, rho_new_im;
    logic                          ue_last, out_last;

    function automatic logic signed [AW-1:0] shr_prod(
        input logic signed [rk4dm_pkg::PROD_W-1:0] p, input int sh);
        logic signed [rk4dm_pkg::PROD_W-1:0] s;
        s = p >>> sh;
        return s[AW-1:0];
    endfunction

    assign in_op   = s_tuser[1:0];
    assign in_row  = s_tdata[1:0];
    assign in_col  = s_tdata[3:2];
    assign in_re   = s_tdata[35:4];
    assign in_im   = s_tdata[67:36];
    assign in_dt   = s_tdata[99:68];
    assign in_xfer = s_tvalid && s_tready;

    assign s_tready = (state_reg == rk4dm_pkg::ST_IDLE);
    assign ue_last  = (ue_reg == rk4dm_pkg::ENT_W'(NE - 1));

    // Operand selection for the shared multiplier.
    always_comb
    begin
        a_sel  = sub_reg[rk4dm_pkg::SUB_W-1:1];
        h_addr = sub_reg[0] ? rk4dm_pkg::ent_idx(a_sel, ci_reg)
                            : rk4dm_pkg::ent_idx(ri_reg, a_sel);
        x_addr = sub_reg[0] ? rk4dm_pkg::ent_idx(ri_reg, a_sel)
                            : rk4dm_pkg::ent_idx(a_sel, ci_reg);
        hs_re  = h_re_reg[h_addr];
        hs_im  = h_im_reg[h_addr];
        xs_re  = (stage_reg == '0) ? rho_re_reg[x_addr] : x_re_reg[x_addr];
        xs_im  = (stage_reg == '0) ? rho_im_reg[x_addr] : x_im_reg[x_addr];
        if (state_reg == rk4dm_pkg::ST_UPD)
        begin
            a_re = rk4dm_pkg::OPND_W'(k_re_reg[ue_reg]);
            a_im = rk4dm_pkg::OPND_W'(k_im_reg[ue_reg]);
            b_re = $signed({1'b0, dt_reg});
            b_im = $signed({1'b0, dt_reg});
        end
        else if (sub_reg[0])
        begin
            a_re = rk4dm_pkg::OPND_W'(xs_re);
            a_im = rk4dm_pkg::OPND_W'(xs_im);
            b_re = rk4dm_pkg::OPND_W'(hs_re);
            b_im = rk4dm_pkg::OPND_W'(hs_im);
        end
        else
        begin
            a_re = rk4dm_pkg::OPND_W'(hs_re);
            a_im = rk4dm_pkg::OPND_W'(hs_im);
            b_re = rk4dm_pkg::OPND_W'(xs_re);
            b_im = rk4dm_pkg::OPND_W'(xs_im);
        end
    end

    rk4dm_cmul u_cmul (
        .clk  (clk),
        .a_re (a_re),
        .a_im (a_im),
        .b_re (b_re),
        .b_im (b_im),
        .prod (prod)
    );

    always_comb
    begin
        tag_issue.valid = (state_reg == rk4dm_pkg::ST_COMM) && !iss_done_reg;
        tag_issue.neg   = sub_reg[0];
        tag_issue.last  = (sub_reg == rk4dm_pkg::SUB_W'(rk4dm_pkg::SUB_STEPS - 1));
        tag_issue.ent   = rk4dm_pkg::ent_idx(ri_reg, ci_reg);
        acc_r_next      = tag2_reg.neg ? acc_r_reg - term_r_reg : acc_r_reg + term_r_reg;
        acc_i_next      = tag2_reg.neg ? acc_i_reg - term_i_reg : acc_i_reg + term_i_reg;
    end

    // Stage point and weighted sum of the stage increments.
    always_comb
    begin
        f_re  = shr_prod(prod.rr, W);
        f_im  = shr_prod(prod.ir, W);
        hh_re = (stage_reg == rk4dm_pkg::STAGE_W'(rk4dm_pkg::HALF_STAGE))
              ? f_re : shr_prod(prod.rr, W + 1);
        hh_im = (stage_reg == rk4dm_pkg::STAGE_W'(rk4dm_pkg::HALF_STAGE))
              ? f_im : shr_prod(prod.ir, W + 1);
        x_new_re = rk4dm_pkg::sat_word(AW'(rho_re_reg[ue_reg]) + hh_re);
        x_new_im = rk4dm_pkg::sat_word(AW'(rho_im_reg[ue_reg]) + hh_im);
        if (stage_reg == '0)
        begin
            t_new_re = f_re;
            t_new_im = f_im;
        end
        else
        begin
            t_new_re = t_re_reg[ue_reg] + (f_re <<< 1);
            t_new_im = t_im_reg[ue_reg] + (f_im <<< 1);
        end
        tf_re = t_re_reg[ue_reg] + f_re;
        tf_im = t_im_reg[ue_reg] + f_im;
        rho_new_re = rk4dm_pkg::sat_word(AW'(rho_re_reg[ue_reg])
                     + $signed(AW'(quo_re)) - rk4dm_pkg::Q_OFFSET);
        rho_new_im = rk4dm_pkg::sat_word(AW'(rho_im_reg[ue_reg])
                     + $signed(AW'(quo_im)) - rk4dm_pkg::Q_OFFSET);
    end

    assign div_start = (state_reg == rk4dm_pkg::ST_UPD) && uph_reg
                       && (stage_reg == rk4dm_pkg::STAGE_W'(rk4dm_pkg::LAST_STAGE));

    rk4dm_div6 u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rk4dm_pkg::DIV_W'(tf_re) + rk4dm_pkg::DIV_OFFSET),
        .quotient (quo_re),
        .done     (div_done_re)
    );

    rk4dm_div6 u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rk4dm_pkg::DIV_W'(tf_im) + rk4dm_pkg::DIV_OFFSET),
        .quotient (quo_im),
        .done     (div_done_im)
    );

    assign out_last = (orow_reg == rk4dm_pkg::IDX_W'(rk4dm_pkg::DIM - 1))
                      && (ocol_reg == rk4dm_pkg::IDX_W'(rk4dm_pkg::DIM - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rk4dm_pkg::ST_IDLE:
            begin
                if (in_xfer && (in_op == rk4dm_pkg::OP_STEP))
                begin
                    state_next = rk4dm_pkg::ST_COMM;
                end
            end
            rk4dm_pkg::ST_COMM:
            begin
                if (tag2_reg.valid && tag2_reg.last
                    && (tag2_reg.ent == rk4dm_pkg::ENT_W'(NE - 1)))
                begin
                    state_next = rk4dm_pkg::ST_UPD;
                end
            end
            rk4dm_pkg::ST_UPD:
            begin
                if (uph_reg)
                begin
                    if (stage_reg == rk4dm_pkg::STAGE_W'(rk4dm_pkg::LAST_STAGE))
                    begin
                        state_next = rk4dm_pkg::ST_DIVW;
                    end
                    else if (ue_last)
                    begin
                        state_next = rk4dm_pkg::ST_COMM;
                    end
                end
            end
            rk4dm_pkg::ST_DIVW:
            begin
                if (div_done_re)
                begin
                    state_next = ue_last ? rk4dm_pkg::ST_OUT : rk4dm_pkg::ST_UPD;
                end
            end
            rk4dm_pkg::ST_OUT:
            begin
                if (m_tready && out_last)
                begin
                    state_next = rk4dm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rk4dm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rk4dm_pkg::ST_IDLE;
            stage_reg    <= '0;
            ri_reg       <= '0;
            ci_reg       <= '0;
            sub_reg      <= '0;
            iss_done_reg <= 1'b0;
            ue_reg       <= '0;
            uph_reg      <= 1'b0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            tag1_reg     <= '0;
            tag2_reg     <= '0;
            for (int e = 0; e < NE; e++)
            begin
                rho_re_reg[e] <= '0;
                rho_im_reg[e] <= '0;
                h_re_reg[e]   <= '0;
                h_im_reg[e]   <= '0;
            end
            rho_re_reg[0] <= W'(64'd1 << (W - 2));
        end
        else
        begin
            state_reg <= state_next;
            tag1_reg  <= tag_issue;
            tag2_reg  <= tag1_reg;
            case (state_reg)
                rk4dm_pkg::ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if ((in_row < rk4dm_pkg::IDX_W'(rk4dm_pkg::DIM))
                            && (in_col < rk4dm_pkg::IDX_W'(rk4dm_pkg::DIM)))
                        begin
                            if (in_op == rk4dm_pkg::OP_LOAD_H)
                            begin
                                h_re_reg[rk4dm_pkg::ent_idx(in_row, in_col)] <= in_re;
                                h_im_reg[rk4dm_pkg::ent_idx(in_row, in_col)] <= in_im;
                            end
                            else if (in_op == rk4dm_pkg::OP_LOAD_RHO)
                            begin
                                rho_re_reg[rk4dm_pkg::ent_idx(in_row, in_col)] <= in_re;
                                rho_im_reg[rk4dm_pkg::ent_idx(in_row, in_col)] <= in_im;
                            end
                        end
                        if (in_op == rk4dm_pkg::OP_STEP)
                        begin
                            stage_reg    <= '0;
                            ri_reg       <= '0;
                            ci_reg       <= '0;
                            sub_reg      <= '0;
                            iss_done_reg <= 1'b0;
                        end
                    end
                end
                rk4dm_pkg::ST_COMM:
                begin
                    if (!iss_done_reg)
                    begin
                        if (tag_issue.last)
                        begin
                            sub_reg <= '0;
                            if (ci_reg == rk4dm_pkg::IDX_W'(rk4dm_pkg::DIM - 1))
                            begin
                                ci_reg <= '0;
                                if (ri_reg == rk4dm_pkg::IDX_W'(rk4dm_pkg::DIM - 1))
                                begin
                                    iss_done_reg <= 1'b1;
                                end
                                else
                                begin
                                    ri_reg <= ri_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                ci_reg <= ci_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 1'b1;
                        end
                    end
                    ue_reg  <= '0;
                    uph_reg <= 1'b0;
                end
                rk4dm_pkg::ST_UPD:
                begin
                    uph_reg <= !uph_reg;
                    if (uph_reg
                        && (stage_reg != rk4dm_pkg::STAGE_W'(rk4dm_pkg::LAST_STAGE)))
                    begin
                        if (ue_last)
                        begin
                            stage_reg    <= stage_reg + 1'b1;
                            ri_reg       <= '0;
                            ci_reg       <= '0;
                            sub_reg      <= '0;
                            iss_done_reg <= 1'b0;
                        end
                        else
                        begin
                            ue_reg <= ue_reg + 1'b1;
                        end
                    end
                end
                rk4dm_pkg::ST_DIVW:
                begin
                    if (div_done_re)
                    begin
                        rho_re_reg[ue_reg] <= rho_new_re;
                        rho_im_reg[ue_reg] <= rho_new_im;
                        if (ue_last)
                        begin
                            orow_reg <= '0;
                            ocol_reg <= '0;
                        end
                        else
                        begin
                            ue_reg <= ue_reg + 1'b1;
                        end
                    end
                end
                rk4dm_pkg::ST_OUT:
                begin
                    if (m_tready)
                    begin
                        if (ocol_reg == rk4dm_pkg::IDX_W'(rk4dm_pkg::DIM - 1))
                        begin
                            ocol_reg <= '0;
                            orow_reg <= orow_reg + 1'b1;
                        end
                        else
                        begin
                            ocol_reg <= ocol_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    uph_reg <= 1'b0;
                end
            endcase
        end
    end

    // Datapath storage without reset.
    always_ff @(posedge clk)
    begin
        term_r_reg <= shr_prod(prod.rr, rk4dm_pkg::H_FRAC)
                      - shr_prod(prod.ii, rk4dm_pkg::H_FRAC);
        term_i_reg <= shr_prod(prod.ri, rk4dm_pkg::H_FRAC)
                      + shr_prod(prod.ir, rk4dm_pkg::H_FRAC);
        if (in_xfer && (in_op == rk4dm_pkg::OP_STEP))
        begin
            dt_reg    <= in_dt;
            acc_r_reg <= '0;
            acc_i_reg <= '0;
        end
        else if (tag2_reg.valid)
        begin
            if (tag2_reg.last)
            begin
                k_re_reg[tag2_reg.ent] <= rk4dm_pkg::sat_word(acc_i_next);
                k_im_reg[tag2_reg.ent] <= rk4dm_pkg::sat_word(-acc_r_next);
                acc_r_reg <= '0;
                acc_i_reg <= '0;
            end
            else
            begin
                acc_r_reg <= acc_r_next;
                acc_i_reg <= acc_i_next;
            end
        end
        if ((state_reg == rk4dm_pkg::ST_UPD) && uph_reg
            && (stage_reg != rk4dm_pkg::STAGE_W'(rk4dm_pkg::LAST_STAGE)))
        begin
            x_re_reg[ue_reg] <= x_new_re;
            x_im_reg[ue_reg] <= x_new_im;
            t_re_reg[ue_reg] <= t_new_re;
            t_im_reg[ue_reg] <= t_new_im;
        end
    end

    assign out_ent  = rk4dm_pkg::ent_idx(orow_reg, ocol_reg);
    assign m_tvalid = (state_reg == rk4dm_pkg::ST_OUT);
    assign m_tlast  = out_last;
    assign m_tdata  = {{rk4dm_pkg::OUT_PAD_W{1'b0}}, rho_im_reg[out_ent],
                       rho_re_reg[out_ent], ocol_reg, orow_reg};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rk4_density_matrix_step_core. Loads of the
// Hamiltonian and density stores and RK4 steps are streamed in bursts. A
// fixed-point model of the von Neumann step predicts the nine entries that
// each step emits, and every output transfer is compared in order.
// ----------------------------------------------------------------------------
module testbench;
    import rk4dm_pkg::*;

    localparam int  LIMIT_CYCLES = 2000000;
    localparam int  SETTLE       = 600;
    localparam longint WMAX      = 64'sd2147483647;
    localparam longint WMIN      = -64'sd2147483648;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] dt;
        bit          drain;
    } cmd_t;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] re;
        logic [31:0] im;
        logic        last;
    } entry_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    cmd_t   cmd_q[$];
    entry_t rho_expected[$];
    int     errors = 0;
    int     cycles = 0;
    int     quiet  = 0;
    int     burst_left = 0;
    int     gap_left   = 0;
    int     hold_left  = 0;
    int     ready_mode = 0;
    int     mode_left  = 0;
    int     results_seen = 0;
    bit     hold_done  = 0;

    longint rho_re[9], rho_im[9], ham_re[9], ham_im[9];
    longint pt_re[9], pt_im[9];
    longint k_re[4][9], k_im[4][9];

    rk4_density_matrix_step_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WMAX)
        begin
            return WMAX;
        end
        if (v < WMIN)
        begin
            return WMIN;
        end
        return v;
    endfunction

    function automatic longint hmul(input longint a, input longint b);
        return (a * b) >>> H_FRAC;
    endfunction

    function automatic longint scale_dt(input longint k, input longint dt, input int sh);
        return (k * dt) >>> sh;
    endfunction

    function automatic longint div6_floor(input longint x);
        if (x >= 0)
        begin
            return x / 6;
        end
        return -((-x + 5) / 6);
    endfunction

    // Stage s = -i (H X - X H), with X held in pt_re / pt_im.
    function automatic void commutator(input int s);
        longint sr, si;
        int ha, xa, xb, hb;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sr = 0;
                si = 0;
                for (int a = 0; a < 3; a++)
                begin
                    ha = i * 3 + a;
                    xa = a * 3 + j;
                    xb = i * 3 + a;
                    hb = a * 3 + j;
                    sr += hmul(ham_re[ha], pt_re[xa]) - hmul(ham_im[ha], pt_im[xa]);
                    si += hmul(ham_re[ha], pt_im[xa]) + hmul(ham_im[ha], pt_re[xa]);
                    sr -= hmul(pt_re[xb], ham_re[hb]) - hmul(pt_im[xb], ham_im[hb]);
                    si -= hmul(pt_re[xb], ham_im[hb]) + hmul(pt_im[xb], ham_re[hb]);
                end
                k_re[s][i*3+j] = clamp_word(si);
                k_im[s][i*3+j] = clamp_word(-sr);
            end
        end
    endfunction

    function automatic void stage_point(input int s, input longint dt, input int sh);
        for (int e = 0; e < 9; e++)
        begin
            pt_re[e] = clamp_word(rho_re[e] + scale_dt(k_re[s][e], dt, sh));
            pt_im[e] = clamp_word(rho_im[e] + scale_dt(k_im[s][e], dt, sh));
        end
    endfunction

    function automatic void apply_transfer(input cmd_t c);
        longint dt, tr, ti;
        entry_t x;
        int e;
        e = int'(c.row) * 3 + int'(c.col);
        if (c.op == OP_LOAD_H || c.op == OP_LOAD_RHO)
        begin
            if (c.row < 3 && c.col < 3)
            begin
                if (c.op == OP_LOAD_H)
                begin
                    ham_re[e] = longint'(signed'(c.re));
                    ham_im[e] = longint'(signed'(c.im));
                end
                else
                begin
                    rho_re[e] = longint'(signed'(c.re));
                    rho_im[e] = longint'(signed'(c.im));
                end
            end
            return;
        end
        if (c.op != OP_STEP)
        begin
            return;
        end
        dt = longint'({32'd0, c.dt});
        pt_re = rho_re;
        pt_im = rho_im;
        commutator(0);
        stage_point(0, dt, WORD_BITS + 1);
        commutator(1);
        stage_point(1, dt, WORD_BITS + 1);
        commutator(2);
        stage_point(2, dt, WORD_BITS);
        commutator(3);
        for (int n = 0; n < 9; n++)
        begin
            tr = scale_dt(k_re[0][n], dt, WORD_BITS) + 2 * scale_dt(k_re[1][n], dt, WORD_BITS)
               + 2 * scale_dt(k_re[2][n], dt, WORD_BITS) + scale_dt(k_re[3][n], dt, WORD_BITS);
            ti = scale_dt(k_im[0][n], dt, WORD_BITS) + 2 * scale_dt(k_im[1][n], dt, WORD_BITS)
               + 2 * scale_dt(k_im[2][n], dt, WORD_BITS) + scale_dt(k_im[3][n], dt, WORD_BITS);
            rho_re[n] = clamp_word(rho_re[n] + div6_floor(tr));
            rho_im[n] = clamp_word(rho_im[n] + div6_floor(ti));
            x.row  = 2'(n / 3);
            x.col  = 2'(n % 3);
            x.re   = rho_re[n][31:0];
            x.im   = rho_im[n][31:0];
            x.last = (n == 8);
            rho_expected.push_back(x);
        end
    endfunction

    function automatic void add_cmd(input logic [1:0] op, input logic [1:0] row,
                                    input logic [1:0] col, input logic [31:0] re,
                                    input logic [31:0] im, input logic [31:0] dt);
        cmd_t c;
        c.op = op;
        c.row = row;
        c.col = col;
        c.re = re;
        c.im = im;
        c.dt = dt;
        c.drain = 0;
        cmd_q.push_back(c);
    endfunction

    function automatic void add_drain();
        cmd_t c;
        c = '{default: '0};
        c.drain = 1;
        cmd_q.push_back(c);
    endfunction

    function automatic logic [31:0] rand_small(input int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    initial
    begin
        int items;
        int r;
        for (int e = 0; e < 9; e++)
        begin
            rho_re[e] = 0;
            rho_im[e] = 0;
            ham_re[e] = 0;
            ham_im[e] = 0;
        end
        rho_re[0] = 64'sd1 << (WORD_BITS - 2);

        add_cmd(OP_STEP, 2'd0, 2'd0, 32'd0, 32'd0, 32'hFFFFFFFF);
        add_cmd(OP_LOAD_H, 2'd0, 2'd1, 32'h0100_0000, 32'hFF00_0000, 32'd0);
        add_cmd(OP_LOAD_H, 2'd1, 2'd0, 32'h0100_0000, 32'h0100_0000, 32'd0);
        add_cmd(OP_LOAD_H, 2'd2, 2'd2, 32'h0080_0000, 32'd0, 32'd0);
        add_cmd(OP_STEP, 2'd0, 2'd0, 32'd0, 32'd0, 32'd0);
        add_cmd(OP_STEP, 2'd0, 2'd0, 32'd0, 32'd0, 32'h1000_0000);
        add_cmd(2'd3, 2'd1, 2'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_cmd(OP_LOAD_H, 2'd3, 2'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0);
        add_cmd(OP_LOAD_RHO, 2'd0, 2'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0);
        add_cmd(OP_LOAD_RHO, 2'd3, 2'd3, 32'h8000_0000, 32'h8000_0000, 32'd0);
        add_cmd(OP_STEP, 2'd3, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h8000_0000);
        add_drain();
        add_cmd(OP_LOAD_H, 2'd0, 2'd0, 32'h7FFFFFFF, 32'h8000_0000, 32'd0);
        add_cmd(OP_LOAD_H, 2'd1, 2'd2, 32'h8000_0000, 32'h7FFFFFFF, 32'd0);
        add_cmd(OP_LOAD_H, 2'd2, 2'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0);
        add_cmd(OP_LOAD_RHO, 2'd0, 2'd0, 32'h7FFFFFFF, 32'h8000_0000, 32'd0);
        add_cmd(OP_LOAD_RHO, 2'd1, 2'd2, 32'h8000_0000, 32'h7FFFFFFF, 32'd0);
        add_cmd(OP_LOAD_RHO, 2'd2, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'd0);
        add_cmd(OP_STEP, 2'd0, 2'd0, 32'd0, 32'd0, 32'hFFFFFFFF);
        add_cmd(OP_STEP, 2'd0, 2'd0, 32'd0, 32'd0, 32'd1);
        add_drain();

        items = 20;
        while (items < 240)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                add_cmd(2'($urandom), 2'($urandom), 2'($urandom), $urandom, $urandom,
                        $urandom);
                items++;
            end
            else
            begin
                for (int e = 0; e < 9; e++)
                begin
                    if ($urandom_range(3) != 0)
                    begin
                        add_cmd(OP_LOAD_H, 2'(e / 3), 2'(e % 3), rand_small(1 << 26),
                                rand_small(1 << 26), $urandom);
                        items++;
                    end
                end
                for (int e = 0; e < 9; e++)
                begin
                    if ($urandom_range(2) == 0)
                    begin
                        add_cmd(OP_LOAD_RHO, 2'(e / 3), 2'(e % 3), rand_small(1 << 29),
                                rand_small(1 << 29), $urandom);
                        items++;
                    end
                end
                r = $urandom_range(1, 4);
                for (int s = 0; s < r; s++)
                begin
                    add_cmd(OP_STEP, 2'($urandom), 2'($urandom), $urandom, $urandom,
                            ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1 << 24)));
                    items++;
                end
            end
            if ($urandom_range(9) == 0)
            begin
                add_drain();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t c;
        logic offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
            quiet      <= 0;
        end
        else
        begin
            quiet <= (rho_expected.size() == 0) ? quiet + 1 : 0;
            if (s_tvalid && s_tready)
            begin
                apply_transfer(cmd_q.pop_front());
            end
            if (!(s_tvalid && !s_tready))
            begin
                offer = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (cmd_q.size() != 0 && cmd_q[0].drain)
                begin
                    if (rho_expected.size() == 0 && quiet >= SETTLE)
                    begin
                        void'(cmd_q.pop_front());
                    end
                end
                else if (cmd_q.size() != 0)
                begin
                    offer = 1'b1;
                    c = cmd_q[0];
                    s_tdata <= {4'd0, c.dt, c.im, c.re, c.col, c.row};
                    s_tuser <= c.op;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            mode_left  <= 0;
            ready_mode <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && results_seen >= 60)
        begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left  <= $urandom_range(20, 300);
                ready_mode <= $urandom_range(2);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(1) == 0);
                default: m_tready <= ($urandom_range(4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        entry_t x;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (rho_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                x = rho_expected.pop_front();
                if (m_tdata[1:0] !== x.row || m_tdata[3:2] !== x.col
                    || m_tdata[35:4] !== x.re || m_tdata[67:36] !== x.im
                    || m_tdata[71:68] !== 4'd0 || m_tlast !== x.last)
                begin
                    errors++;
                    $display("%0t: mismatch, expected row %0d col %0d re %h im %h last %b",
                             $time, x.row, x.col, x.re, x.im, x.last);
                    $display("%0t:           actual row %0d col %0d re %h im %h last %b",
                             $time, m_tdata[1:0], m_tdata[3:2], m_tdata[35:4],
                             m_tdata[67:36], m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("[rk4_density_matrix_step_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (cmd_q.size() != 0 || s_tvalid || rho_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && rho_expected.size() == 0)
        begin
            $display("[rk4_density_matrix_step_core] OK");
        end
        else
        begin
            $display("[rk4_density_matrix_step_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rk4dm_pkg.sv
rtl/rk4dm_cmul.sv
rtl/rk4dm_div6.sv
rtl/rk4_density_matrix_step_core.sv
sim/testbench.sv
